FILE: rtl/dfa_pkg.sv
// Shared types and constants of the table-driven word acceptor.
package dfa_pkg;

  // Fixed widths of the request and result fields.
  localparam int STATE_W = 4;
  localparam int ENTRY_W = STATE_W + 1;
  localparam int SYM_W   = 8;
  localparam int ERR_W   = 2;

  // Default sizes of the automaton.
  localparam int NUM_STATES_DEF  = 16;
  localparam int SYMBOL_BITS_DEF = 8;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_WRITE_TRANS = 2'd0,
    CMD_SET_ALPHA   = 2'd1,
    CMD_FEED        = 2'd2,
    CMD_CHECK_EMPTY = 2'd3
  } cmd_t;

  // Word error codes.
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ALPHABET = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_TRANS = 2'd2;

  // Configuration register indexes.
  typedef enum logic {
    REG_START_STATE = 1'b0,
    REG_FINAL_MASK  = 1'b1
  } reg_index_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } ctrl_state_t;

endpackage

FILE: rtl/dfa_word_acceptor.sv
// Top level of the programmable table-driven word acceptor.
//
//  Channel   Handshake            Payload
//  --------  -------------------  -----------------------------------------------
//  request   start, busy          cmd, symbol, from_state, to_state, entry_valid,
//                                 in_alphabet, first, last
//  result    done (one cycle)     accepted, error_code, end_state
//  config    psel/penable/pwrite  paddr, pwdata, prdata, pready
//
//  After reset a clearing pass over all 2**($clog2(NUM_STATES) + SYMBOL_BITS)
//  table entries (4096 by default) empties the table and alphabet; busy is high.
//  A table write, an alphabet write or an empty-word check is taken in ST_IDLE.
//  A fed symbol goes via ST_LOOKUP: the next state comes from the synchronous
//  transition table memory, addressed by the current state and the symbol.
//  A result is shown with done for one cycle after its request has finished;
//  the receiver cannot stall it.
module dfa_word_acceptor #(
  parameter int NUM_STATES  = dfa_pkg::NUM_STATES_DEF,
  parameter int SYMBOL_BITS = dfa_pkg::SYMBOL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Request channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd,
  input  logic [dfa_pkg::SYM_W-1:0]   symbol,
  input  logic [dfa_pkg::STATE_W-1:0] from_state,
  input  logic [dfa_pkg::STATE_W-1:0] to_state,
  input  logic                        entry_valid,
  input  logic                        in_alphabet,
  input  logic                        first,
  input  logic                        last,
  // Result channel
  output logic                        done,
  output logic                        accepted,
  output logic [dfa_pkg::ERR_W-1:0]   error_code,
  output logic [dfa_pkg::STATE_W-1:0] end_state,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  import dfa_pkg::*;

  localparam int STATE_AW  = $clog2(NUM_STATES);
  localparam int TBL_AW    = STATE_AW + SYMBOL_BITS;
  localparam int TBL_DEPTH = 1 << TBL_AW;
  localparam int SYM_DEPTH = 1 << SYMBOL_BITS;

  // Configuration registers
  logic [STATE_W-1:0] start_state;
  logic [15:0]        final_mask;

  // Controller
  ctrl_state_t        state;
  ctrl_state_t        state_next;
  logic [TBL_AW-1:0]  clr_cnt;
  logic               accept;
  logic               cfg_write;

  // Word state
  logic [STATE_W-1:0] cur_state;
  logic [ERR_W-1:0]   word_err;
  logic               lk_sym_ok;
  logic               lk_last;

  // Memory ports
  logic                   tbl_we;
  logic [TBL_AW-1:0]      tbl_waddr;
  logic [ENTRY_W-1:0]     tbl_wdata;
  logic [TBL_AW-1:0]      tbl_raddr;
  logic [ENTRY_W-1:0]     tbl_rdata;
  logic                   alp_we;
  logic [SYMBOL_BITS-1:0] alp_waddr;
  logic                   alp_wdata;
  logic                   alp_rdata;

  // Request decode
  logic               sym_ok;
  logic               from_ok;
  logic [STATE_W-1:0] eff_cur;
  logic [ERR_W-1:0]   eff_err;
  logic [STATE_W-1:0] cur_next;
  logic [ERR_W-1:0]   err_next;

  assign sym_ok  = (symbol >> SYMBOL_BITS) == '0;
  assign from_ok = 32'(from_state) < NUM_STATES;
  assign eff_cur = first ? start_state : cur_state;
  assign eff_err = first ? ERR_NONE : word_err;

  // Lookup addresses are driven from the request itself.
  assign tbl_raddr = {STATE_AW'(eff_cur), symbol[SYMBOL_BITS-1:0]};

  // The transition table: a valid bit over the destination state.
  dfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // The alphabet: one membership bit per symbol.
  dfa_ram #(
    .WIDTH (1),
    .DEPTH (SYM_DEPTH)
  ) u_alp_ram (
    .clk   (clk),
    .we    (alp_we),
    .waddr (alp_waddr),
    .wdata (alp_wdata),
    .raddr (symbol[SYMBOL_BITS-1:0]),
    .rdata (alp_rdata)
  );

  // Controller next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == {TBL_AW{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && cmd == CMD_FEED) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Controller outputs: handshake and memory writes.
  always_comb begin
    busy      = 1'b1;
    accept    = 1'b0;
    tbl_we    = 1'b0;
    tbl_waddr = clr_cnt;
    tbl_wdata = '0;
    alp_we    = 1'b0;
    alp_waddr = clr_cnt[SYMBOL_BITS-1:0];
    alp_wdata = 1'b0;
    case (state)
      ST_CLEAR: begin
        tbl_we = 1'b1;
        alp_we = 1'b1;
      end
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
        case (cmd_t'(cmd))
          CMD_WRITE_TRANS: begin
            tbl_we    = start && sym_ok && from_ok;
            tbl_waddr = {STATE_AW'(from_state), symbol[SYMBOL_BITS-1:0]};
            tbl_wdata = entry_valid ? {1'b1, to_state} : '0;
          end
          CMD_SET_ALPHA: begin
            alp_we    = start && sym_ok;
            alp_waddr = symbol[SYMBOL_BITS-1:0];
            alp_wdata = in_alphabet;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Step of the automaton once the table and alphabet reads have returned.
  always_comb begin
    cur_next = cur_state;
    err_next = word_err;
    if (word_err == ERR_NONE) begin
      if (!lk_sym_ok || !alp_rdata) begin
        err_next = ERR_ALPHABET;
      end else if (32'(cur_state) >= NUM_STATES) begin
        err_next = ERR_NO_TRANS;
      end else if (tbl_rdata[ENTRY_W-1]) begin
        cur_next = tbl_rdata[STATE_W-1:0];
      end else begin
        err_next = ERR_NO_TRANS;
      end
    end
  end

  // Controller and clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Word state: restarted on a first symbol, stepped after the lookup.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= '0;
      word_err  <= ERR_NONE;
    end else if (accept && cmd == CMD_FEED) begin
      cur_state <= eff_cur;
      word_err  <= eff_err;
    end else if (state == ST_LOOKUP) begin
      cur_state <= cur_next;
      word_err  <= err_next;
    end
  end

  // Marks of the symbol under lookup.
  always_ff @(posedge clk) begin
    if (accept) begin
      lk_sym_ok <= sym_ok;
      lk_last   <= last;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && cmd == CMD_CHECK_EMPTY) || (state == ST_LOOKUP && lk_last);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_CHECK_EMPTY) begin
      accepted   <= final_mask[start_state];
      error_code <= ERR_NONE;
      end_state  <= start_state;
    end else if (state == ST_LOOKUP) begin
      accepted   <= (err_next == ERR_NONE) && final_mask[cur_next];
      error_code <= err_next;
      end_state  <= cur_next;
    end
  end

  // Configuration register writes.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= '0;
      final_mask  <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(paddr[2]))
        REG_START_STATE: start_state <= pwdata[STATE_W-1:0];
        REG_FINAL_MASK:  final_mask  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_START_STATE: prdata = {28'd0, start_state};
      REG_FINAL_MASK:  prdata = {16'd0, final_mask};
      default:         prdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  // A result only follows a finished lookup or an empty-word check.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_LOOKUP || (accept && cmd == CMD_CHECK_EMPTY)))
    else $error("result strobe without a finished request");

  // An accepted word never carries an error.
  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    (done && accepted) |-> (error_code == ERR_NONE))
    else $error("accepted word reported with an error");

  // The clearing pass only ends once every table entry has been written.
  a_clear_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && $past(state == ST_CLEAR)) |-> $past(clr_cnt == {TBL_AW{1'b1}}))
    else $error("clearing pass ended early");

  // No request is taken while a lookup is in flight.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |-> (busy && !tbl_we && !alp_we))
    else $error("memory written during a lookup");
`endif

endmodule

FILE: rtl/dfa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dfa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
